@@ hdl/lsi_pkg.sv @@
// Shared types, indication codes and decode function for the LED status indicator.
// Used by every module of the block; no dependencies.
`default_nettype none
package lsi_pkg;

   localparam int unsigned CODE_WIDTH = 5;
   localparam int unsigned CFG_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [CODE_WIDTH-1:0] IND_IDLE      = 5'd0;
   localparam logic [CODE_WIDTH-1:0] IND_SCAN      = 5'd1;
   localparam logic [CODE_WIDTH-1:0] IND_ADV       = 5'd2;
   localparam logic [CODE_WIDTH-1:0] IND_WHITELIST = 5'd3;
   localparam logic [CODE_WIDTH-1:0] IND_SLOW      = 5'd4;
   localparam logic [CODE_WIDTH-1:0] IND_DIRECTED  = 5'd5;
   localparam logic [CODE_WIDTH-1:0] IND_BOND      = 5'd6;
   localparam logic [CODE_WIDTH-1:0] IND_CONN      = 5'd7;
   localparam logic [CODE_WIDTH-1:0] IND_SENT_OK   = 5'd8;
   localparam logic [CODE_WIDTH-1:0] IND_SEND_ERR  = 5'd9;
   localparam logic [CODE_WIDTH-1:0] IND_RCV_OK    = 5'd10;
   localparam logic [CODE_WIDTH-1:0] IND_RCV_ERR   = 5'd11;
   localparam logic [CODE_WIDTH-1:0] IND_FATAL     = 5'd12;
   localparam logic [CODE_WIDTH-1:0] IND_ALERT0    = 5'd13;
   localparam logic [CODE_WIDTH-1:0] IND_ALERT1    = 5'd14;
   localparam logic [CODE_WIDTH-1:0] IND_ALERT2    = 5'd15;
   localparam logic [CODE_WIDTH-1:0] IND_ALERT3    = 5'd16;
   localparam logic [CODE_WIDTH-1:0] IND_ALERT_OFF = 5'd17;
   localparam logic [CODE_WIDTH-1:0] IND_USER_OFF  = 5'd18;
   localparam logic [CODE_WIDTH-1:0] IND_USER0     = 5'd19;
   localparam logic [CODE_WIDTH-1:0] IND_USER1     = 5'd20;
   localparam logic [CODE_WIDTH-1:0] IND_USER2     = 5'd21;
   localparam logic [CODE_WIDTH-1:0] IND_USER3     = 5'd22;
   localparam logic [CODE_WIDTH-1:0] IND_USER_ON   = 5'd23;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADV_ON     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADV_OFF    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAST_ON    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAST_OFF   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLOW_ON    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLOW_OFF   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLASH      = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ERR_FLASH  = 3'd7;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_IDLE,
      OP_TOGGLE,
      OP_BOND,
      OP_CONN,
      OP_FLASH,
      OP_ALL_ON,
      OP_ALERT,
      OP_ALERT_OFF,
      OP_USER
   } op_type;

   typedef struct packed {
      logic                  func;
      logic [CODE_WIDTH-1:0] indication;
   } req_type;

   typedef struct packed {
      logic [3:0]            led_pattern;
      logic                  alert_active;
      logic [CODE_WIDTH-1:0] stable_mode;
   } rsp_type;

   typedef struct packed {
      logic                  is_tick;
      op_type                op;
      logic [CODE_WIDTH-1:0] code;
   } entry_type;

   function automatic op_type classify(input logic [CODE_WIDTH-1:0] code);
      op_type op;
      case (code)
         IND_IDLE:                                      op = OP_IDLE;
         IND_ADV, IND_WHITELIST, IND_SLOW, IND_DIRECTED: op = OP_TOGGLE;
         IND_BOND:                                      op = OP_BOND;
         IND_CONN:                                      op = OP_CONN;
         IND_SENT_OK, IND_SEND_ERR, IND_RCV_OK, IND_RCV_ERR: op = OP_FLASH;
         IND_FATAL, IND_USER_ON:                        op = OP_ALL_ON;
         IND_ALERT0, IND_ALERT1, IND_ALERT2, IND_ALERT3: op = OP_ALERT;
         IND_ALERT_OFF:                                 op = OP_ALERT_OFF;
         IND_USER_OFF, IND_USER0, IND_USER1, IND_USER2: op = OP_USER;
         default:                                       op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage
`default_nettype wire

@@ hdl/lsi_front.sv @@
// Front end: accepts request words and classifies them into queue entries.
// Depends on lsi_pkg.
`default_nettype none
module lsi_front (
   input  wire lsi_pkg::req_type   req_data,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire                     q_full,
   output logic                    q_push,
   output lsi_pkg::entry_type      q_entry
);
   import lsi_pkg::*;

   assign req_ready = !q_full;
   assign q_push = req_valid && !q_full;

   always_comb begin
      q_entry.is_tick = req_data.func;
      q_entry.code = req_data.indication;
      q_entry.op = req_data.func ? OP_NONE : classify(req_data.indication);
   end

endmodule
`default_nettype wire

@@ hdl/lsi_queue.sv @@
// Two-entry queue between front and back end.
// Depends on lsi_pkg.
`default_nettype none
module lsi_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire lsi_pkg::entry_type push_entry,
   input  wire                     pop,
   output logic                    full,
   output logic                    not_empty,
   output lsi_pkg::entry_type      head
);
   import lsi_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]         count_ff, count_in;

   assign full = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/lsi_back.sv @@
// Back end: LED state, blink and alert timers, config registers, response register.
// Depends on lsi_pkg.
`default_nettype none
module lsi_back #(
   parameter int unsigned NUM_LEDS = 4,
   parameter int unsigned ALERT_LED = 3,
   parameter int unsigned TIMER_WIDTH = 16,
   parameter int unsigned DIRECTED_ON_TICKS = 5,
   parameter int unsigned DIRECTED_OFF_TICKS = 5,
   parameter int unsigned ALERT_TICKS = 20
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     csr_wr_en,
   input  wire [lsi_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  wire [lsi_pkg::CFG_WIDTH-1:0]            csr_wdata,
   input  wire                                     q_not_empty,
   input  wire lsi_pkg::entry_type                 q_head,
   output logic                                    q_pop,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output lsi_pkg::rsp_type                        rsp_data
);
   import lsi_pkg::*;

   localparam logic [NUM_LEDS-1:0] ALERT_MASK = NUM_LEDS'(32'd1 << ALERT_LED);
   localparam logic [NUM_LEDS-1:0] LED1_MASK = NUM_LEDS'(2);
   localparam logic [32:0] T_MAX = (33'd1 << TIMER_WIDTH) - 33'd1;
   localparam logic [31:0] DIR_ON = 32'(DIRECTED_ON_TICKS);
   localparam logic [31:0] DIR_OFF = 32'(DIRECTED_OFF_TICKS);
   localparam logic [31:0] ALERT_P4 = 32'(4 * ALERT_TICKS);
   localparam logic [31:0] ALERT_P3 = 32'(3 * ALERT_TICKS);
   localparam logic [31:0] ALERT_P2 = 32'(2 * ALERT_TICKS);

   function automatic logic [TIMER_WIDTH-1:0] fit_len(input logic [31:0] n);
      logic [32:0] w;
      w = {1'b0, n};
      if (w > T_MAX) w = T_MAX;
      if (w == 33'd0) w = 33'd1;
      return w[TIMER_WIDTH-1:0];
   endfunction

   logic [CFG_WIDTH-1:0]   cfg_ff [8];

   logic [NUM_LEDS-1:0]    led_ff, led_in;
   logic [CODE_WIDTH-1:0]  stable_ff, stable_in;
   logic                   clr_ff, clr_in;
   logic                   alert_ff, alert_in;
   logic [TIMER_WIDTH-1:0] blink_cnt_ff, blink_cnt_in;
   logic                   blink_run_ff, blink_run_in;
   logic [TIMER_WIDTH-1:0] alert_cnt_ff, alert_cnt_in;
   logic [TIMER_WIDTH-1:0] alert_per_ff, alert_per_in;
   logic                   alert_run_ff, alert_run_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   do_apply;
   logic [CODE_WIDTH-1:0]  acode;
   op_type                 aop;
   logic [31:0]            on_len, off_len, alert_len;
   logic [7:0]             led_ext;

   assign q_pop = q_not_empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      led_in = led_ff;
      stable_in = stable_ff;
      clr_in = clr_ff;
      alert_in = alert_ff;
      blink_cnt_in = blink_cnt_ff;
      blink_run_in = blink_run_ff;
      alert_cnt_in = alert_cnt_ff;
      alert_per_in = alert_per_ff;
      alert_run_in = alert_run_ff;
      do_apply = 1'b0;
      acode = q_head.code;
      aop = q_head.op;

      if (q_pop) begin
         if (q_head.is_tick) begin
            if (blink_run_ff) begin
               if (blink_cnt_ff <= TIMER_WIDTH'(1)) begin
                  blink_run_in = 1'b0;
                  blink_cnt_in = '0;
                  do_apply = 1'b1;
                  acode = stable_ff;
                  aop = classify(stable_ff);
               end else begin
                  blink_cnt_in = blink_cnt_ff - 1'b1;
               end
            end
         end else begin
            do_apply = 1'b1;
         end
      end

      case (acode)
         IND_ADV: begin
            on_len = 32'(cfg_ff[CSR_ADV_ON]);
            off_len = 32'(cfg_ff[CSR_ADV_OFF]);
         end
         IND_WHITELIST: begin
            on_len = 32'(cfg_ff[CSR_FAST_ON]);
            off_len = 32'(cfg_ff[CSR_FAST_OFF]);
         end
         IND_SLOW: begin
            on_len = 32'(cfg_ff[CSR_SLOW_ON]);
            off_len = 32'(cfg_ff[CSR_SLOW_OFF]);
         end
         default: begin
            on_len = DIR_ON;
            off_len = DIR_OFF;
         end
      endcase

      case (acode)
         IND_ALERT0: alert_len = ALERT_P4;
         IND_ALERT1: alert_len = ALERT_P3;
         default:    alert_len = ALERT_P2;
      endcase

      if (do_apply) begin
         if (clr_in) begin
            clr_in = 1'b0;
            led_in = alert_in ? (led_in & ALERT_MASK) : '0;
         end
         case (aop)
            OP_IDLE: begin
               led_in = alert_in ? (led_in & ALERT_MASK) : '0;
               blink_run_in = 1'b0;
               stable_in = acode;
            end
            OP_TOGGLE: begin
               if (led_in[0]) begin
                  led_in[0] = 1'b0;
                  blink_cnt_in = fit_len(off_len);
               end else begin
                  led_in[0] = 1'b1;
                  blink_cnt_in = fit_len(on_len);
               end
               blink_run_in = 1'b1;
               stable_in = acode;
            end
            OP_BOND: begin
               led_in[0] = !led_in[0];
               stable_in = acode;
               blink_cnt_in = fit_len(32'(cfg_ff[CSR_FLASH]));
               blink_run_in = 1'b1;
            end
            OP_CONN: begin
               led_in[0] = 1'b1;
               stable_in = acode;
            end
            OP_FLASH: begin
               clr_in = 1'b1;
               led_in = led_in ^ LED1_MASK;
               // odd codes are the error flashes
               blink_cnt_in = acode[0] ? fit_len(32'(cfg_ff[CSR_ERR_FLASH]))
                                       : fit_len(32'(cfg_ff[CSR_FLASH]));
               blink_run_in = 1'b1;
            end
            OP_ALL_ON: begin
               led_in = '1;
               stable_in = acode;
            end
            OP_ALERT: begin
               alert_run_in = 1'b0;
               if (acode != IND_ALERT3) begin
                  alert_per_in = fit_len(alert_len);
                  alert_cnt_in = fit_len(alert_len);
                  alert_run_in = 1'b1;
               end
               led_in = led_in | ALERT_MASK;
               alert_in = 1'b1;
            end
            OP_ALERT_OFF: begin
               alert_run_in = 1'b0;
               led_in = led_in & ~ALERT_MASK;
               alert_in = 1'b0;
            end
            OP_USER: begin
               led_in = alert_in ? (led_in & ALERT_MASK) : '0;
               if (acode == IND_USER0 || acode == IND_USER2) led_in[0] = 1'b1;
               if (acode == IND_USER1 || acode == IND_USER2) led_in = led_in | LED1_MASK;
               stable_in = acode;
            end
            default: begin
            end
         endcase
      end

      if (q_pop && q_head.is_tick && alert_run_in) begin
         if (alert_cnt_in <= TIMER_WIDTH'(1)) begin
            led_in = led_in ^ ALERT_MASK;
            alert_cnt_in = alert_per_in;
         end else begin
            alert_cnt_in = alert_cnt_in - 1'b1;
         end
      end

      led_ext = 8'(led_in);
      rsp_data_in.led_pattern = led_ext[3:0];
      rsp_data_in.alert_active = alert_in;
      rsp_data_in.stable_mode = stable_in;
      rsp_valid_in = q_pop ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (reset) begin
         cfg_ff[CSR_ADV_ON] <= 16'd10;
         cfg_ff[CSR_ADV_OFF] <= 16'd90;
         cfg_ff[CSR_FAST_ON] <= 16'd10;
         cfg_ff[CSR_FAST_OFF] <= 16'd40;
         cfg_ff[CSR_SLOW_ON] <= 16'd40;
         cfg_ff[CSR_SLOW_OFF] <= 16'd400;
         cfg_ff[CSR_FLASH] <= 16'd10;
         cfg_ff[CSR_ERR_FLASH] <= 16'd50;
         led_ff <= '0;
         stable_ff <= IND_IDLE;
         clr_ff <= 1'b0;
         alert_ff <= 1'b0;
         blink_cnt_ff <= '0;
         blink_run_ff <= 1'b0;
         alert_cnt_ff <= '0;
         alert_per_ff <= '0;
         alert_run_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cfg_ff[csr_index] <= csr_wdata;
         end
         led_ff <= led_in;
         stable_ff <= stable_in;
         clr_ff <= clr_in;
         alert_ff <= alert_in;
         blink_cnt_ff <= blink_cnt_in;
         blink_run_ff <= blink_run_in;
         alert_cnt_ff <= alert_cnt_in;
         alert_per_ff <= alert_per_in;
         alert_run_ff <= alert_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/led_status_indicator.sv @@
// LED status indicator: top level joining front end, queue and back end.
// Depends on lsi_pkg, lsi_front, lsi_queue, lsi_back.
//
// Usage:
//   req channel (req_valid/req_ready/req_data): one word per item, either an
//     indication command (func 0) or one time tick (func 1).
//   rsp channel (rsp_valid/rsp_ready/rsp_data): exactly one word per request
//     word, in order: LED vector, alert flag and stable indication after it.
//   csr port: csr_wr_en, csr_index, csr_wdata write one of the eight tick
//     count registers; write only while the block is idle.
// A request enters the queue, then is popped into the response register.
// Throughput: one word per cycle while the receiver does not stall; the back
//   end updates all state for a word as it pops it.
// A two-word queue sits between front and back. When the receiver stalls, the
//   response register holds, the queue fills and req_ready drops once it is
//   full; no word is lost.
// Reset clears LEDs, timers and flags, sets the stable indication to idle,
//   restores the default register values and empties the queue.
`default_nettype none
module led_status_indicator #(
   parameter int unsigned NUM_LEDS = 4,
   parameter int unsigned ALERT_LED = 3,
   parameter int unsigned TIMER_WIDTH = 16,
   parameter int unsigned DIRECTED_ON_TICKS = 5,
   parameter int unsigned DIRECTED_OFF_TICKS = 5,
   parameter int unsigned ALERT_TICKS = 20
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire lsi_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output lsi_pkg::rsp_type                   rsp_data,
   input  wire                                csr_wr_en,
   input  wire [lsi_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire [lsi_pkg::CFG_WIDTH-1:0]       csr_wdata
);
   import lsi_pkg::*;

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_not_empty;
   entry_type q_entry;
   entry_type q_head;

   lsi_front u_front (
      .req_data (req_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   lsi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_entry),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   lsi_back #(
      .NUM_LEDS          (NUM_LEDS),
      .ALERT_LED         (ALERT_LED),
      .TIMER_WIDTH       (TIMER_WIDTH),
      .DIRECTED_ON_TICKS (DIRECTED_ON_TICKS),
      .DIRECTED_OFF_TICKS(DIRECTED_OFF_TICKS),
      .ALERT_TICKS       (ALERT_TICKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_not_empty(q_not_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

@@ hdl/lsi_checker.sv @@
// Port-level assertions for the LED status indicator, bound to the top level.
// Depends on lsi_pkg and led_status_indicator.
`default_nettype none
module lsi_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_ready,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input wire lsi_pkg::rsp_type rsp_data
);
   import lsi_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   a_stable_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.stable_mode == IND_IDLE
         || (rsp_data.stable_mode >= IND_ADV && rsp_data.stable_mode <= IND_CONN)
         || rsp_data.stable_mode == IND_FATAL
         || (rsp_data.stable_mode >= IND_USER_OFF && rsp_data.stable_mode <= IND_USER2)
         || rsp_data.stable_mode == IND_USER_ON))
      else $error("stable mode holds a non-stable code");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with no response pending");

endmodule

bind led_status_indicator lsi_checker u_lsi_checker (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
`default_nettype wire

@@ sim/tb_led_status_indicator.sv @@
// Self-checking testbench for led_status_indicator: directed rows, then random words
// under several idle/stall mixes, checked against an in-bench LED model or typed row values.
// Depends on lsi_pkg and the led_status_indicator RTL.
module tb_led_status_indicator;
   import lsi_pkg::*;

   localparam logic [3:0]            LED_ALL     = 4'hF;
   localparam logic [3:0]            ALERT_MASK  = 4'h8;
   localparam int unsigned           DIR_ON      = 5;
   localparam int unsigned           DIR_OFF     = 5;
   localparam int unsigned           ALERT_BASE  = 20;
   localparam int                    HOLD_CYCLES = 40;
   localparam int                    PHASE_WORDS = 255;
   localparam int                    NUM_ROWS    = 27;
   localparam logic [CODE_WIDTH-1:0] IND_TOP     = 5'd31;
   localparam logic                  TICK = 1'b1, CMD = 1'b0;
   localparam logic                  TYPED = 1'b1, MODEL = 1'b0;

   typedef struct packed {
      logic                  tick;
      logic [CODE_WIDTH-1:0] code;
      logic                  typed;
      rsp_type               want;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_type      req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_type      rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CFG_WIDTH-1:0]       csr_wdata = '0;

   // model state
   logic [CFG_WIDTH-1:0]  ticks_cfg [8] = '{16'd10, 16'd90, 16'd10, 16'd40,
                                            16'd40, 16'd400, 16'd10, 16'd50};
   logic [3:0]            led_now = '0;
   logic [CODE_WIDTH-1:0] stable_now = IND_IDLE;
   logic                  clear_due = 1'b0;
   logic                  alert_on = 1'b0;
   logic [15:0]           blink_cnt = '0;
   logic                  blink_on = 1'b0;
   logic [15:0]           alert_cnt = '0;
   logic [15:0]           alert_len = '0;
   logic                  alert_run = 1'b0;

   rsp_type due_status [$];
   int      mismatches = 0;
   int      idle_pct = 0;
   int      stall_pct = 0;
   int      holds_asked = 0;
   int      holds_done = 0;
   logic    row_typed = 1'b0;
   rsp_type row_want = '0;

   dir_row_type dir_rows [NUM_ROWS] = '{
      '{TICK, IND_IDLE,      TYPED, '{4'h0, 1'b0, IND_IDLE}},
      '{TICK, IND_TOP,       TYPED, '{4'h0, 1'b0, IND_IDLE}},
      '{CMD,  IND_FATAL,     TYPED, '{4'hF, 1'b0, IND_FATAL}},
      '{CMD,  IND_IDLE,      TYPED, '{4'h0, 1'b0, IND_IDLE}},
      '{CMD,  IND_USER_ON,   TYPED, '{4'hF, 1'b0, IND_USER_ON}},
      '{CMD,  IND_SCAN,      TYPED, '{4'hF, 1'b0, IND_USER_ON}},
      '{CMD,  IND_TOP,       TYPED, '{4'hF, 1'b0, IND_USER_ON}},
      '{CMD,  IND_USER_OFF,  TYPED, '{4'h0, 1'b0, IND_USER_OFF}},
      '{CMD,  IND_USER2,     TYPED, '{4'h3, 1'b0, IND_USER2}},
      '{CMD,  IND_USER3,     TYPED, '{4'h3, 1'b0, IND_USER2}},
      '{CMD,  IND_ALERT3,    TYPED, '{4'hB, 1'b1, IND_USER2}},
      '{CMD,  IND_USER0,     TYPED, '{4'h9, 1'b1, IND_USER0}},
      '{CMD,  IND_ALERT_OFF, TYPED, '{4'h1, 1'b0, IND_USER0}},
      '{CMD,  IND_SENT_OK,   MODEL, '0},
      '{CMD,  IND_RCV_ERR,   MODEL, '0},
      '{CMD,  IND_ADV,       MODEL, '0},
      '{CMD,  IND_WHITELIST, MODEL, '0},
      '{CMD,  IND_SLOW,      MODEL, '0},
      '{CMD,  IND_DIRECTED,  MODEL, '0},
      '{CMD,  IND_BOND,      MODEL, '0},
      '{CMD,  IND_CONN,      MODEL, '0},
      '{CMD,  IND_SEND_ERR,  MODEL, '0},
      '{CMD,  IND_RCV_OK,    MODEL, '0},
      '{CMD,  IND_ALERT0,    MODEL, '0},
      '{CMD,  IND_ALERT1,    MODEL, '0},
      '{CMD,  IND_ALERT2,    MODEL, '0},
      '{CMD,  IND_USER1,     MODEL, '0}
   };

   led_status_indicator #(
      .NUM_LEDS(4),
      .ALERT_LED(3),
      .TIMER_WIDTH(16),
      .DIRECTED_ON_TICKS(DIR_ON),
      .DIRECTED_OFF_TICKS(DIR_OFF),
      .ALERT_TICKS(ALERT_BASE)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void start_blink(input logic [15:0] len);
      blink_cnt = (len == 0) ? 16'd1 : len;
      blink_on = 1'b1;
   endfunction

   function automatic void clear_except_alert();
      led_now = alert_on ? (led_now & ALERT_MASK) : 4'h0;
   endfunction

   function automatic void toggle_led0(input logic [CODE_WIDTH-1:0] code,
                                       input logic [15:0] on_t, input logic [15:0] off_t);
      if (led_now[0]) begin
         led_now[0] = 1'b0;
         start_blink(off_t);
      end else begin
         led_now[0] = 1'b1;
         start_blink(on_t);
      end
      stable_now = code;
   endfunction

   function automatic void flash_led1(input logic [15:0] len);
      clear_due = 1'b1;
      led_now[1] = ~led_now[1];
      start_blink(len);
   endfunction

   function automatic void apply_indication(input logic [CODE_WIDTH-1:0] code);
      if (clear_due) begin
         clear_due = 1'b0;
         clear_except_alert();
      end
      case (code)
         IND_IDLE: begin
            clear_except_alert();
            blink_on = 1'b0;
            stable_now = code;
         end
         IND_ADV:       toggle_led0(code, ticks_cfg[CSR_ADV_ON], ticks_cfg[CSR_ADV_OFF]);
         IND_WHITELIST: toggle_led0(code, ticks_cfg[CSR_FAST_ON], ticks_cfg[CSR_FAST_OFF]);
         IND_SLOW:      toggle_led0(code, ticks_cfg[CSR_SLOW_ON], ticks_cfg[CSR_SLOW_OFF]);
         IND_DIRECTED:  toggle_led0(code, 16'(DIR_ON), 16'(DIR_OFF));
         IND_BOND: begin
            led_now[0] = ~led_now[0];
            stable_now = code;
            start_blink(ticks_cfg[CSR_FLASH]);
         end
         IND_CONN: begin
            led_now[0] = 1'b1;
            stable_now = code;
         end
         IND_SENT_OK, IND_RCV_OK:  flash_led1(ticks_cfg[CSR_FLASH]);
         IND_SEND_ERR, IND_RCV_ERR: flash_led1(ticks_cfg[CSR_ERR_FLASH]);
         IND_FATAL, IND_USER_ON: begin
            led_now = LED_ALL;
            stable_now = code;
         end
         IND_ALERT0, IND_ALERT1, IND_ALERT2: begin
            alert_len = 16'(ALERT_BASE * (32'(IND_ALERT3) - 32'(code) + 1));
            alert_cnt = alert_len;
            alert_run = 1'b1;
            led_now = led_now | ALERT_MASK;
            alert_on = 1'b1;
         end
         IND_ALERT3: begin
            alert_run = 1'b0;
            led_now = led_now | ALERT_MASK;
            alert_on = 1'b1;
         end
         IND_ALERT_OFF: begin
            alert_run = 1'b0;
            led_now = led_now & ~ALERT_MASK;
            alert_on = 1'b0;
         end
         IND_USER_OFF, IND_USER0, IND_USER1, IND_USER2: begin
            clear_except_alert();
            if (code == IND_USER0 || code == IND_USER2) led_now[0] = 1'b1;
            if (code == IND_USER1 || code == IND_USER2) led_now[1] = 1'b1;
            stable_now = code;
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_type advance_status(input req_type w);
      rsp_type r;
      if (!w.func) begin
         apply_indication(w.indication);
      end else begin
         if (blink_on) begin
            if (blink_cnt <= 1) begin
               blink_on = 1'b0;
               blink_cnt = '0;
               apply_indication(stable_now);
            end else begin
               blink_cnt = blink_cnt - 1'b1;
            end
         end
         if (alert_run) begin
            if (alert_cnt <= 1) begin
               led_now = led_now ^ ALERT_MASK;
               alert_cnt = alert_len;
            end else begin
               alert_cnt = alert_cnt - 1'b1;
            end
         end
      end
      r.led_pattern = led_now;
      r.alert_active = alert_on;
      r.stable_mode = stable_now;
      return r;
   endfunction

   function automatic logic [CODE_WIDTH-1:0] pick_code();
      int r;
      r = $urandom_range(99);
      if (r < 10) return CODE_WIDTH'($urandom_range(IND_ALERT_OFF, IND_ALERT0));
      if (r < 25) return CODE_WIDTH'($urandom_range(IND_RCV_ERR, IND_SENT_OK));
      if (r < 85) return CODE_WIDTH'($urandom_range(IND_FATAL, IND_IDLE));
      if (r < 95) return CODE_WIDTH'($urandom_range(IND_USER_ON, IND_USER_OFF));
      return CODE_WIDTH'($urandom_range(IND_TOP, IND_IDLE));
   endfunction

   task automatic check_field(input string name, input logic [4:0] want,
                              input logic [4:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_status.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word, expected none, got %h", $time, rsp_data);
            end else begin
               want = due_status.pop_front();
               check_field("led_pattern", 5'(want.led_pattern), 5'(rsp_data.led_pattern));
               check_field("alert_active", 5'(want.alert_active), 5'(rsp_data.alert_active));
               check_field("stable_mode", want.stable_mode, rsp_data.stable_mode);
            end
         end
         if (req_valid && req_ready) begin
            want = advance_status(req_data);
            due_status.push_back(row_typed ? row_want : want);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input req_type w, input logic typed, input rsp_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = w;
      row_typed = typed;
      row_want = want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (due_status.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   initial begin : receiver
      forever begin
         @(negedge clock);
         if (holds_done < holds_asked) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end
         rsp_ready = ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin : stimulus
      req_type w;
      int      n, burst, ph, lo, hi;
      logic    extremes;
      logic [CFG_WIDTH-1:0] v;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         w.func = dir_rows[i].tick;
         w.indication = dir_rows[i].code;
         send_word(w, dir_rows[i].typed, dir_rows[i].want);
      end
      drain();

      for (ph = 0; ph < 6; ph++) begin
         extremes = 1'b0;
         lo = 1;
         hi = 12;
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 84; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 84; extremes = 1'b1; end
            3: begin idle_pct = 8;  stall_pct = 8;  hi = 30; end
            4: begin idle_pct = 0;  stall_pct = 0;  lo = 0; hi = 3; end
            default: begin idle_pct = 8; stall_pct = 8; hi = 6; end
         endcase
         // first phase runs on the reset defaults
         if (ph != 0) begin
            for (int r = 0; r < 8; r++) begin
               v = extremes ? (r[0] ? 16'hFFFF : 16'd1) : CFG_WIDTH'($urandom_range(hi, lo));
               csr_wr_en = 1'b1;
               csr_index = CSR_INDEX_WIDTH'(r);
               csr_wdata = v;
               ticks_cfg[r] = v;
               @(negedge clock);
            end
            csr_wr_en = 1'b0;
            @(negedge clock);
         end
         if (ph == 0 || ph == 4) holds_asked++;

         n = 0;
         while (n < PHASE_WORDS) begin
            if ($urandom_range(99) < 1) begin
               burst = $urandom_range(120, 20);
               repeat (burst) begin
                  w.func = 1'b1;
                  w.indication = CODE_WIDTH'($urandom());
                  send_word(w, 1'b0, '0);
               end
               n += burst;
            end else begin
               w.func = ($urandom_range(99) < 70);
               w.indication = w.func ? CODE_WIDTH'($urandom()) : pick_code();
               send_word(w, 1'b0, '0);
               n++;
            end
         end
         drain();
      end

      repeat (4) @(negedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
